// File: rtl/core/pse_pkg.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Shared types, codes and saturation helpers for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int COUNT_W         = 6;
  localparam int DIV_STEPS       = 48;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_DRAIN = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       stack_count;
    status_t                  status;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic                     start;
    alu_op_t                  op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] result;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_CALC,
    S_RESULT,
    S_DRAIN_EMIT,
    S_DRAIN_WAIT
  } state_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_SIGN,
    AS_DONE
  } alu_state_t;

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [47:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[47:DATA_W-1]) || !(|v[47:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[47] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pse_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pse_alu.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator arithmetic unit
// Saturating Q16.16 add, subtract, multiply and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  output pse_pkg::alu_rsp_t rsp
);

  pse_pkg::alu_state_t state;
  pse_pkg::alu_state_t state_next;

  logic signed [pse_pkg::DATA_W-1:0]   res;
  logic signed [2*pse_pkg::DATA_W-1:0] prod;
  logic [47:0]                         quot;
  logic [pse_pkg::DATA_W-1:0]          rem;
  logic [pse_pkg::DATA_W-1:0]          dvs;
  logic                                neg;
  logic [pse_pkg::DIV_CNT_W-1:0]       cnt;

  logic [pse_pkg::DATA_W-1:0] a_mag;
  logic [pse_pkg::DATA_W-1:0] b_mag;
  logic [pse_pkg::DATA_W:0]   rem_sh;
  logic [pse_pkg::DATA_W+1:0] diff;
  logic                       ge;
  logic [47:0]                neg_q;
  logic signed [pse_pkg::DATA_W-1:0] div_res;
  logic                       div_last;

  assign a_mag    = req.a[pse_pkg::DATA_W-1] ? (~$unsigned(req.a) + 32'd1) : $unsigned(req.a);
  assign b_mag    = req.b[pse_pkg::DATA_W-1] ? (~$unsigned(req.b) + 32'd1) : $unsigned(req.b);
  assign rem_sh   = {rem, quot[47]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge       = !diff[pse_pkg::DATA_W+1];
  assign neg_q    = 48'd0 - quot;
  assign div_last = (cnt == pse_pkg::DIV_CNT_W'(pse_pkg::DIV_STEPS - 1));

  always_comb begin
    if (!neg) begin
      div_res = (|quot[47:31]) ? 32'sh7fff_ffff : $signed({1'b0, quot[30:0]});
    end else begin
      div_res = (quot > 48'h0000_8000_0000) ? 32'sh8000_0000 : $signed(neg_q[31:0]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pse_pkg::AS_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            pse_pkg::ALU_MUL: state_next = pse_pkg::AS_MUL;
            pse_pkg::ALU_DIV: state_next = pse_pkg::AS_DIV;
            default:          state_next = pse_pkg::AS_DONE;
          endcase
        end
      end
      pse_pkg::AS_MUL:  state_next = pse_pkg::AS_DONE;
      pse_pkg::AS_DIV:  state_next = div_last ? pse_pkg::AS_SIGN : pse_pkg::AS_DIV;
      pse_pkg::AS_SIGN: state_next = pse_pkg::AS_DONE;
      pse_pkg::AS_DONE: state_next = pse_pkg::AS_IDLE;
      default:          state_next = pse_pkg::AS_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state == pse_pkg::AS_DONE);
    rsp.result = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pse_pkg::AS_IDLE: begin
        if (req.start) begin
          case (req.op)
            pse_pkg::ALU_ADD: res <= pse_pkg::sat33(33'(req.a) + 33'(req.b));
            pse_pkg::ALU_SUB: res <= pse_pkg::sat33(33'(req.a) - 33'(req.b));
            pse_pkg::ALU_MUL: prod <= req.a * req.b;
            default: begin
              quot <= {a_mag, 16'd0};
              rem  <= '0;
              dvs  <= b_mag;
              neg  <= req.a[pse_pkg::DATA_W-1] ^ req.b[pse_pkg::DATA_W-1];
              cnt  <= '0;
            end
          endcase
        end
      end
      pse_pkg::AS_MUL: res <= pse_pkg::sat48(prod[2*pse_pkg::DATA_W-1:16]);
      pse_pkg::AS_DIV: begin
        rem  <= ge ? diff[pse_pkg::DATA_W-1:0] : rem_sh[pse_pkg::DATA_W-1:0];
        quot <= {quot[46:0], ge};
        cnt  <= cnt + pse_pkg::DIV_CNT_W'(1);
      end
      pse_pkg::AS_SIGN: res <= div_res;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/postfix_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator core
// Evaluates postfix expressions on a saturating Q16.16 operand stack.
// ----------------------------------------------------------------------------
//  Channel  Handshake                  Payload
//  item     item_valid / item_ready    pse_pkg::in_item_t  (op, operand_value)
//  result   result_valid / result_ready pse_pkg::out_item_t (top, count, status, last)
//
// One item is taken at a time. A push, an overflow, an underflow, an unused
// code or an empty drain goes through decode and result steps; arithmetic
// adds fetch and ALU steps, skipping the ALU on divide by zero, and divide
// runs the one-bit-per-cycle divider. A drain emits entries with a wait step
// between them for the registered read of the stack RAM. Reset empties the
// stack at once. A stalled result holds the sequencer at its result step.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pse_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output pse_pkg::out_item_t result
);

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  pse_pkg::state_t state;
  pse_pkg::state_t state_next;

  logic [SP_W-1:0]                   sp;
  logic [2:0]                        op_reg;
  logic signed [pse_pkg::DATA_W-1:0] val_reg;
  logic signed [pse_pkg::DATA_W-1:0] top_reg;
  logic signed [pse_pkg::DATA_W-1:0] pend_value;
  logic [SP_W-1:0]                   pend_count;
  pse_pkg::status_t                  pend_status;
  logic                              out_valid;
  pse_pkg::out_item_t                out_item;

  logic [SP_W-1:0]                   sp_m1;
  logic [SP_W-1:0]                   sp_m2;
  logic                              full;
  logic                              short;
  logic                              is_arith;
  logic                              div_zero;
  logic                              slot_free;
  logic                              load_out;
  logic signed [pse_pkg::DATA_W-1:0] cur_top;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [pse_pkg::DATA_W-1:0] ram_wdata;
  logic [pse_pkg::DATA_W-1:0] ram_rdata;

  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;

  assign sp_m1     = sp - SP_W'(1);
  assign sp_m2     = sp - SP_W'(2);
  assign full      = (sp == SP_W'(STACK_DEPTH));
  assign short     = (sp < SP_W'(2));
  assign is_arith  = (op_reg == pse_pkg::OP_ADD) || (op_reg == pse_pkg::OP_SUB) ||
                     (op_reg == pse_pkg::OP_MUL) || (op_reg == pse_pkg::OP_DIV);
  assign div_zero  = (op_reg == pse_pkg::OP_DIV) && (top_reg == '0);
  assign slot_free = !out_valid || result_ready;
  assign load_out  = slot_free &&
                     ((state == pse_pkg::S_RESULT) || (state == pse_pkg::S_DRAIN_EMIT));
  assign cur_top   = (sp == '0) ? '0 : top_reg;

  assign item_ready   = (state == pse_pkg::S_IDLE);
  assign result_valid = out_valid;
  assign result       = out_item;

  pse_ram #(
    .WIDTH (pse_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sp_m2[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  pse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      pse_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = pse_pkg::S_DECODE;
        end
      end
      pse_pkg::S_DECODE: begin
        if (is_arith && !short) begin
          state_next = pse_pkg::S_FETCH;
        end else if ((op_reg == pse_pkg::OP_DRAIN) && (sp != '0)) begin
          state_next = pse_pkg::S_DRAIN_EMIT;
        end else begin
          state_next = pse_pkg::S_RESULT;
        end
      end
      pse_pkg::S_FETCH: state_next = div_zero ? pse_pkg::S_RESULT : pse_pkg::S_CALC;
      pse_pkg::S_CALC: begin
        if (alu_rsp.done) begin
          state_next = pse_pkg::S_RESULT;
        end
      end
      pse_pkg::S_RESULT: begin
        if (slot_free) begin
          state_next = pse_pkg::S_IDLE;
        end
      end
      pse_pkg::S_DRAIN_EMIT: begin
        if (slot_free) begin
          state_next = (sp == SP_W'(1)) ? pse_pkg::S_IDLE : pse_pkg::S_DRAIN_WAIT;
        end
      end
      pse_pkg::S_DRAIN_WAIT: state_next = pse_pkg::S_DRAIN_EMIT;
      default:               state_next = pse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = sp[ADDR_W-1:0];
    ram_wdata     = val_reg;
    alu_req.start = 1'b0;
    alu_req.a     = $signed(ram_rdata);
    alu_req.b     = top_reg;
    unique case (op_reg)
      pse_pkg::OP_ADD: alu_req.op = pse_pkg::ALU_ADD;
      pse_pkg::OP_SUB: alu_req.op = pse_pkg::ALU_SUB;
      pse_pkg::OP_MUL: alu_req.op = pse_pkg::ALU_MUL;
      default:         alu_req.op = pse_pkg::ALU_DIV;
    endcase
    unique case (state)
      pse_pkg::S_DECODE: begin
        ram_we = (op_reg == pse_pkg::OP_PUSH) && !full;
      end
      pse_pkg::S_FETCH: begin
        alu_req.start = !div_zero;
      end
      pse_pkg::S_CALC: begin
        ram_we    = alu_rsp.done;
        ram_waddr = sp_m2[ADDR_W-1:0];
        ram_wdata = alu_rsp.result;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pse_pkg::S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        pse_pkg::S_IDLE: begin
          if (item_valid) begin
            op_reg  <= item.op;
            val_reg <= item.operand_value;
          end
        end
        pse_pkg::S_DECODE: begin
          unique case (op_reg) inside
            pse_pkg::OP_PUSH: begin
              if (full) begin
                pend_value  <= cur_top;
                pend_count  <= sp;
                pend_status <= pse_pkg::ST_OVERFLOW;
              end else begin
                top_reg     <= val_reg;
                sp          <= sp + SP_W'(1);
                pend_value  <= val_reg;
                pend_count  <= sp + SP_W'(1);
                pend_status <= pse_pkg::ST_OK;
              end
            end
            pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
              pend_value  <= cur_top;
              pend_count  <= sp;
              pend_status <= pse_pkg::ST_UNDERFLOW;
            end
            default: begin
              pend_value  <= cur_top;
              pend_count  <= sp;
              pend_status <= pse_pkg::ST_OK;
            end
          endcase
        end
        pse_pkg::S_FETCH: begin
          pend_status <= pse_pkg::ST_DIV_ZERO;
        end
        pse_pkg::S_CALC: begin
          if (alu_rsp.done) begin
            sp          <= sp_m1;
            top_reg     <= alu_rsp.result;
            pend_value  <= alu_rsp.result;
            pend_count  <= sp_m1;
            pend_status <= pse_pkg::ST_OK;
          end
        end
        pse_pkg::S_RESULT: begin
          if (slot_free) begin
            out_item.top_value   <= pend_value;
            out_item.stack_count <= pse_pkg::COUNT_W'(pend_count);
            out_item.status      <= pend_status;
            out_item.last        <= 1'b1;
          end
        end
        pse_pkg::S_DRAIN_EMIT: begin
          if (slot_free) begin
            out_item.top_value   <= top_reg;
            out_item.stack_count <= pse_pkg::COUNT_W'(sp_m1);
            out_item.status      <= pse_pkg::ST_OK;
            out_item.last        <= (sp == SP_W'(1));
            sp                   <= sp_m1;
          end
        end
        pse_pkg::S_DRAIN_WAIT: begin
          top_reg <= $signed(ram_rdata);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: bench/pse_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator result checker
// Watches the item and result channels of the evaluator core. Each accepted
// item is run through a Q16.16 stack model of its own, and the results it
// yields are queued. Each accepted result is compared field by field with the
// oldest queued one. The failure count and the number of results still due are
// handed back to the bench top.
// ----------------------------------------------------------------------------
module pse_result_checker #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  pse_pkg::in_item_t  item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  pse_pkg::out_item_t result,
  output int                 fail_count,
  output int                 pending_count
);

  logic signed [pse_pkg::DATA_W-1:0] held_values [$];
  pse_pkg::out_item_t                expected_results [$];
  int                                mismatch_total;

  function automatic logic signed [pse_pkg::DATA_W-1:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[pse_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [pse_pkg::DATA_W-1:0] current_top();
    if (held_values.size() == 0) begin
      return '0;
    end
    return held_values[$];
  endfunction

  task automatic queue_result(input logic signed [pse_pkg::DATA_W-1:0] top,
                              input int count, input pse_pkg::status_t st,
                              input logic final_flag);
    pse_pkg::out_item_t e;
    e.top_value   = top;
    e.stack_count = pse_pkg::COUNT_W'(count);
    e.status      = st;
    e.last        = final_flag;
    expected_results.push_back(e);
  endtask

  task automatic evaluate_item(input pse_pkg::in_item_t it);
    longint                            lhs;
    longint                            rhs;
    longint                            res;
    logic signed [pse_pkg::DATA_W-1:0] v;
    case (it.op) inside
      pse_pkg::OP_PUSH: begin
        if (held_values.size() >= STACK_DEPTH) begin
          queue_result(current_top(), held_values.size(), pse_pkg::ST_OVERFLOW, 1'b1);
        end else begin
          held_values.push_back(it.operand_value);
          queue_result(it.operand_value, held_values.size(), pse_pkg::ST_OK, 1'b1);
        end
      end
      pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
        if (held_values.size() < 2) begin
          queue_result(current_top(), held_values.size(), pse_pkg::ST_UNDERFLOW, 1'b1);
        end else begin
          rhs = longint'(held_values[$]);
          lhs = longint'(held_values[$-1]);
          if (it.op == pse_pkg::OP_DIV && rhs == 0) begin
            queue_result(current_top(), held_values.size(), pse_pkg::ST_DIV_ZERO, 1'b1);
          end else begin
            case (it.op)
              pse_pkg::OP_ADD: res = lhs + rhs;
              pse_pkg::OP_SUB: res = lhs - rhs;
              pse_pkg::OP_MUL: res = (lhs * rhs) >>> 16;
              default:         res = (lhs * 65536) / rhs;
            endcase
            v = held_values.pop_back();
            v = held_values.pop_back();
            held_values.push_back(clamp_q16(res));
            queue_result(held_values[$], held_values.size(), pse_pkg::ST_OK, 1'b1);
          end
        end
      end
      pse_pkg::OP_DRAIN: begin
        if (held_values.size() == 0) begin
          queue_result('0, 0, pse_pkg::ST_OK, 1'b1);
        end else begin
          while (held_values.size() > 0) begin
            v = held_values.pop_back();
            queue_result(v, held_values.size(), pse_pkg::ST_OK, held_values.size() == 0);
          end
        end
      end
      default: begin
        queue_result(current_top(), held_values.size(), pse_pkg::ST_OK, 1'b1);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [pse_pkg::DATA_W-1:0] got,
                                 input logic [pse_pkg::DATA_W-1:0] want);
    mismatch_total++;
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_result(input pse_pkg::out_item_t got);
    pse_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", got.top_value, '0);
    end else begin
      want = expected_results.pop_front();
      if (got.top_value !== want.top_value) begin
        report_mismatch("top_value", got.top_value, want.top_value);
      end
      if (got.stack_count !== want.stack_count) begin
        report_mismatch("stack_count", pse_pkg::DATA_W'(got.stack_count),
                        pse_pkg::DATA_W'(want.stack_count));
      end
      if (got.status !== want.status) begin
        report_mismatch("status", pse_pkg::DATA_W'(got.status),
                        pse_pkg::DATA_W'(want.status));
      end
      if (got.last !== want.last) begin
        report_mismatch("last", pse_pkg::DATA_W'(got.last), pse_pkg::DATA_W'(want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      held_values.delete();
    end else begin
      if (item_valid && item_ready) begin
        evaluate_item(item);
      end
      if (result_valid && result_ready) begin
        check_result(result);
      end
    end
    pending_count <= expected_results.size();
    fail_count    <= mismatch_total;
  end

endmodule

// File: bench/tb_postfix_stack_evaluator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator core testbench
// Drives a short directed sequence covering saturation, underflow,
// divide by zero, unused codes and drains, then random expressions, stack
// fills to overflow and noise. The sender works in bursts and the receiver
// stalls on changing patterns. The checker beside the core decides each result.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator_core;

  localparam int         STACK_DEPTH   = pse_pkg::STACK_DEPTH_DEF;
  localparam int         RANDOM_ITEMS  = 350;
  localparam logic [2:0] OP_SPARE_LO   = 3'd6;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  pse_pkg::in_item_t  item;
  logic               result_valid;
  logic               result_ready = 1'b0;
  pse_pkg::out_item_t result;
  int                 fail_count;
  int                 pending_count;

  int        burst_left;
  int        items_sent;
  int        stall_cycle;
  int        stall_mode;
  logic [15:0] stall_pattern;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  postfix_stack_evaluator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  pse_result_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // The receiver changes its stall habit by drawing a new stall mode and pattern.
  always @(posedge clk) begin
    if (stall_cycle % 256 == 0) begin
      stall_mode    = $urandom_range(0, 3);
      stall_pattern = 16'($urandom());
    end
    case (stall_mode)
      0:       result_ready <= 1'b1;
      1:       result_ready <= 1'($urandom_range(0, 1));
      2:       result_ready <= stall_pattern[4'(stall_cycle % 16)];
      default: result_ready <= ($urandom_range(0, 7) == 0);
    endcase
    stall_cycle++;
  end

  function automatic logic signed [pse_pkg::DATA_W-1:0] random_operand();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = 0;
          3:       v = 1;
          4:       v = -1;
          5:       v = 32'sh0001_0000;
          default: v = 32'shFFFF_0000;
        endcase
      end
      1, 2:    v = $urandom();
      default: v = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_arith_op();
    case ($urandom_range(0, 3))
      0:       return pse_pkg::OP_ADD;
      1:       return pse_pkg::OP_SUB;
      2:       return pse_pkg::OP_MUL;
      default: return pse_pkg::OP_DIV;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op_code,
                           input logic signed [pse_pkg::DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= {op_code, value};
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    #20_000_000;
    $display("postfix_stack_evaluator_core verification failed");
    $finish;
  end

  initial begin
    int directed_end;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(pse_pkg::OP_DRAIN, 32'sh1234_5678);
    send_item(pse_pkg::OP_ADD, 32'sh0);
    send_item(pse_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    send_item(pse_pkg::OP_SUB, 32'sh0);
    send_item(pse_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    send_item(pse_pkg::OP_ADD, 32'shFFFF_FFFF);
    send_item(pse_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(pse_pkg::OP_MUL, 32'sh0);
    send_item(pse_pkg::OP_PUSH, 32'sh0);
    send_item(pse_pkg::OP_DIV, 32'sh0);
    send_item(OP_SPARE_LO, 32'shFFFF_FFFF);
    send_item(OP_SPARE_HI, 32'sh0);
    send_item(pse_pkg::OP_DRAIN, 32'sh0);
    send_item(pse_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(pse_pkg::OP_PUSH, 32'shFFFF_0000);
    send_item(pse_pkg::OP_DIV, 32'sh0);
    send_item(pse_pkg::OP_PUSH, 32'sh0000_0001);
    send_item(pse_pkg::OP_PUSH, 32'shFFFF_FFFF);
    send_item(pse_pkg::OP_MUL, 32'sh0);
    send_item(pse_pkg::OP_PUSH, 32'sh0007_0000);
    send_item(pse_pkg::OP_PUSH, 32'shFFFD_0000);
    send_item(pse_pkg::OP_DIV, 32'sh0);
    send_item(pse_pkg::OP_SUB, 32'sh0);
    send_item(pse_pkg::OP_DRAIN, 32'sh0);
    directed_end = items_sent;

    while (items_sent < directed_end + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          repeat (STACK_DEPTH + $urandom_range(1, 3)) begin
            send_item(pse_pkg::OP_PUSH, random_operand());
          end
          repeat ($urandom_range(1, 4)) send_item(random_arith_op(), random_operand());
          send_item(pse_pkg::OP_DRAIN, random_operand());
        end
        1, 2, 3: begin
          repeat ($urandom_range(1, 6)) send_item(3'($urandom_range(0, 7)), $urandom());
        end
        default: begin
          send_item(pse_pkg::OP_PUSH, random_operand());
          send_item(pse_pkg::OP_PUSH, random_operand());
          send_item(random_arith_op(), random_operand());
          repeat ($urandom_range(0, 5)) begin
            send_item(pse_pkg::OP_PUSH, random_operand());
            if ($urandom_range(0, 3) == 0) begin
              send_item(pse_pkg::OP_PUSH, random_operand());
              send_item(random_arith_op(), random_operand());
            end
            send_item(random_arith_op(), random_operand());
          end
          if ($urandom_range(0, 2) == 0) begin
            send_item(pse_pkg::OP_DRAIN, random_operand());
          end
        end
      endcase
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("postfix_stack_evaluator_core verification clean");
    end else begin
      $display("postfix_stack_evaluator_core verification failed");
    end
    $finish;
  end

endmodule
